// ===== sv/dpg_pkg.sv =====
`timescale 1ns / 1ps
package dpg_pkg;

   localparam int MAX_WIDTH    = 256;
   localparam int MAX_HEIGHT   = 384;
   localparam int PREFIX_LIMIT = 24;
   localparam int MAX_RICE_K   = 3;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int DIM_W  = 9;
   localparam int K_W    = 2;
   localparam int PFX_W  = $clog2(PREFIX_LIMIT + 2);
   localparam int SUF_W  = PREFIX_LIMIT;
   localparam int CODE_W = PREFIX_LIMIT + 1;
   localparam int PIX_W  = 8;

   localparam logic [PIX_W-1:0] PIX_MID = 8'd128;
   localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

   localparam int CSR_AW   = 5;
   localparam int CSR_DW   = 32;
   localparam int OQ_DEPTH = 8;
   localparam int OQ_AW    = $clog2(OQ_DEPTH);
   localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

   typedef enum logic [2:0] {
      REG_PRED_MODE  = 3'd0,
      REG_CODE_KIND  = 3'd1,
      REG_RICE_K     = 3'd2,
      REG_IMG_WIDTH  = 3'd3,
      REG_IMG_HEIGHT = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      PRED_LEFT  = 2'd0,
      PRED_ABOVE = 2'd1,
      PRED_AVG   = 2'd2
   } pred_mode_type;

   typedef enum logic {
      KIND_EXPG = 1'b0,
      KIND_RICE = 1'b1
   } code_kind_type;

   typedef struct packed {
      pred_mode_type    pred_mode;
      code_kind_type    code_kind;
      logic [K_W-1:0]   rice_k;
      logic [DIM_W-1:0] img_width;
      logic [DIM_W-1:0] img_height;
   } cfg_type;

   // decoded code on its way to the pixel stage
   typedef struct packed {
      logic              valid;
      logic [CODE_W-1:0] code;
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
      logic              img_end;
      logic              byte_end;
      logic              strm_end;
   } pix_req_type;

   // reconstructed pixel on its way to the output queue
   typedef struct packed {
      logic             valid;
      logic [PIX_W-1:0] value;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             img_end;
      logic             byte_end;
      logic             strm_end;
   } pix_res_type;

   typedef struct packed {
      logic [PIX_W-1:0] value;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             last_of_byte;
      logic             frame_complete;
   } out_item_type;

endpackage

// ===== sv/dpg_csr.sv =====
`timescale 1ns / 1ps
module dpg_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [dpg_pkg::CSR_AW-1:0] paddr,
   input  logic [dpg_pkg::CSR_DW-1:0] pwdata,
   output logic [dpg_pkg::CSR_DW-1:0] prdata,
   output logic                       pready,
   output dpg_pkg::cfg_type           cfg
);

   dpg_pkg::cfg_type       cfg_ff;
   dpg_pkg::reg_index_type index_w;
   logic                   write_w;

   assign index_w = dpg_pkg::reg_index_type'(paddr[dpg_pkg::CSR_AW-1:2]);
   assign write_w = psel & penable & pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pred_mode  <= dpg_pkg::PRED_LEFT;
         cfg_ff.code_kind  <= dpg_pkg::KIND_EXPG;
         cfg_ff.rice_k     <= '0;
         cfg_ff.img_width  <= dpg_pkg::DIM_W'(128);
         cfg_ff.img_height <= dpg_pkg::DIM_W'(144);
      end else if (write_w) begin
         unique case (index_w)
            dpg_pkg::REG_PRED_MODE:
               cfg_ff.pred_mode <= dpg_pkg::pred_mode_type'(pwdata[1:0]);
            dpg_pkg::REG_CODE_KIND:
               cfg_ff.code_kind <= dpg_pkg::code_kind_type'(pwdata[0]);
            dpg_pkg::REG_RICE_K:
               cfg_ff.rice_k <= pwdata[dpg_pkg::K_W-1:0];
            dpg_pkg::REG_IMG_WIDTH:
               cfg_ff.img_width <= pwdata[dpg_pkg::DIM_W-1:0];
            dpg_pkg::REG_IMG_HEIGHT:
               cfg_ff.img_height <= pwdata[dpg_pkg::DIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (index_w)
         dpg_pkg::REG_PRED_MODE:  prdata = dpg_pkg::CSR_DW'(cfg_ff.pred_mode);
         dpg_pkg::REG_CODE_KIND:  prdata = dpg_pkg::CSR_DW'(cfg_ff.code_kind);
         dpg_pkg::REG_RICE_K:     prdata = dpg_pkg::CSR_DW'(cfg_ff.rice_k);
         dpg_pkg::REG_IMG_WIDTH:  prdata = dpg_pkg::CSR_DW'(cfg_ff.img_width);
         dpg_pkg::REG_IMG_HEIGHT: prdata = dpg_pkg::CSR_DW'(cfg_ff.img_height);
         default:                 prdata = '0;
      endcase
   end

endmodule

// ===== sv/dpg_decoder.sv =====
`timescale 1ns / 1ps
module dpg_decoder (
   input  logic                    clock,
   input  logic                    reset,
   input  dpg_pkg::cfg_type        cfg,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_stream_byte,
   input  logic                    req_stream_end,
   input  logic                    room,
   output dpg_pkg::pix_req_type    pix_req
);

   logic [7:0]                  byte_ff;
   logic                        end_ff;
   logic [2:0]                  idx_ff;
   logic                        full_ff;
   logic                        in_suffix_ff, in_suffix_in;
   logic [dpg_pkg::PFX_W-1:0]   prefix_ff, prefix_in;
   logic [dpg_pkg::SUF_W-1:0]   suffix_ff, suffix_in;
   logic [dpg_pkg::PFX_W-1:0]   remain_ff, remain_in;
   logic [dpg_pkg::COL_W-1:0]   col_ff, col_in;
   logic [dpg_pkg::ROW_W-1:0]   row_ff, row_in;
   logic                        done_ff, done_in;

   logic                        advance_w, last_bit_w, bit_w, accept_w;
   logic                        emit_w, row_end_w, img_end_w;
   logic [dpg_pkg::CODE_W-1:0]  code_w, eg_code_w, rice_code_w;
   logic [dpg_pkg::SUF_W-1:0]   suf_new_w;
   logic [dpg_pkg::K_W-1:0]     k_eff_w;
   logic [dpg_pkg::DIM_W-1:0]   w_eff_w, h_eff_w;

   assign advance_w  = full_ff & room;
   assign last_bit_w = (idx_ff == 3'd7);
   assign bit_w      = byte_ff[7];
   assign req_stall  = full_ff & ~(advance_w & last_bit_w);
   assign accept_w   = req_valid & ~req_stall;

   assign k_eff_w = (cfg.rice_k > dpg_pkg::K_W'(dpg_pkg::MAX_RICE_K)) ?
                    dpg_pkg::K_W'(dpg_pkg::MAX_RICE_K) : cfg.rice_k;
   assign w_eff_w = (cfg.img_width == '0) ? dpg_pkg::DIM_W'(1) :
                    (cfg.img_width > dpg_pkg::DIM_W'(dpg_pkg::MAX_WIDTH)) ?
                    dpg_pkg::DIM_W'(dpg_pkg::MAX_WIDTH) : cfg.img_width;
   assign h_eff_w = (cfg.img_height == '0) ? dpg_pkg::DIM_W'(1) :
                    (cfg.img_height > dpg_pkg::DIM_W'(dpg_pkg::MAX_HEIGHT)) ?
                    dpg_pkg::DIM_W'(dpg_pkg::MAX_HEIGHT) : cfg.img_height;

   // code numbers with the incoming bit already shifted into the suffix
   assign suf_new_w   = {suffix_ff[dpg_pkg::SUF_W-2:0], bit_w};
   assign eg_code_w   = (dpg_pkg::CODE_W'(1) << prefix_ff) - dpg_pkg::CODE_W'(1)
                        + dpg_pkg::CODE_W'(suf_new_w);
   assign rice_code_w = (dpg_pkg::CODE_W'(prefix_ff) << k_eff_w)
                        + dpg_pkg::CODE_W'(suf_new_w);

   always_comb begin
      in_suffix_in = in_suffix_ff;
      prefix_in    = prefix_ff;
      suffix_in    = suffix_ff;
      remain_in    = remain_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      done_in      = done_ff;
      emit_w       = 1'b0;
      code_w       = '0;
      row_end_w    = 1'b0;
      img_end_w    = 1'b0;

      if (advance_w && !done_ff) begin
         if (!in_suffix_ff) begin
            if (!bit_w) begin
               // long run of zeros closes the code with a zero difference
               if (prefix_ff == dpg_pkg::PFX_W'(dpg_pkg::PREFIX_LIMIT)) begin
                  emit_w = 1'b1;
                  prefix_in = '0;
               end else begin
                  prefix_in = prefix_ff + dpg_pkg::PFX_W'(1);
               end
            end else if (cfg.code_kind == dpg_pkg::KIND_EXPG) begin
               if (prefix_ff == '0) begin
                  emit_w = 1'b1;
               end else begin
                  in_suffix_in = 1'b1;
                  suffix_in    = '0;
                  remain_in    = prefix_ff;
               end
            end else begin
               if (k_eff_w == '0) begin
                  emit_w    = 1'b1;
                  code_w    = dpg_pkg::CODE_W'(prefix_ff);
                  prefix_in = '0;
               end else begin
                  in_suffix_in = 1'b1;
                  suffix_in    = '0;
                  remain_in    = dpg_pkg::PFX_W'(k_eff_w);
               end
            end
         end else begin
            if (remain_ff <= dpg_pkg::PFX_W'(1)) begin
               emit_w       = 1'b1;
               code_w       = (cfg.code_kind == dpg_pkg::KIND_EXPG) ? eg_code_w : rice_code_w;
               in_suffix_in = 1'b0;
               prefix_in    = '0;
               suffix_in    = '0;
               remain_in    = '0;
            end else begin
               suffix_in = suf_new_w;
               remain_in = remain_ff - dpg_pkg::PFX_W'(1);
            end
         end
      end

      if (emit_w) begin
         row_end_w = (dpg_pkg::DIM_W'(col_ff) + dpg_pkg::DIM_W'(1)) >= w_eff_w;
         img_end_w = row_end_w &&
                     ((dpg_pkg::DIM_W'(row_ff) + dpg_pkg::DIM_W'(1)) >= h_eff_w);
         if (row_end_w) begin
            col_in = '0;
            if (img_end_w) begin
               done_in = 1'b1;
            end else begin
               row_in = row_ff + dpg_pkg::ROW_W'(1);
            end
         end else begin
            col_in = col_ff + dpg_pkg::COL_W'(1);
         end
      end

      // end of stream drops a cut-short code and starts a new frame
      if (advance_w && last_bit_w && end_ff) begin
         in_suffix_in = 1'b0;
         prefix_in    = '0;
         suffix_in    = '0;
         remain_in    = '0;
         col_in       = '0;
         row_in       = '0;
         done_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff      <= 1'b0;
         idx_ff       <= '0;
         in_suffix_ff <= 1'b0;
         prefix_ff    <= '0;
         suffix_ff    <= '0;
         remain_ff    <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         done_ff      <= 1'b0;
      end else begin
         in_suffix_ff <= in_suffix_in;
         prefix_ff    <= prefix_in;
         suffix_ff    <= suffix_in;
         remain_ff    <= remain_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         done_ff      <= done_in;
         if (accept_w) begin
            full_ff <= 1'b1;
            idx_ff  <= '0;
         end else if (advance_w) begin
            idx_ff <= idx_ff + 3'd1;
            if (last_bit_w) begin
               full_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept_w) begin
         byte_ff <= req_stream_byte;
         end_ff  <= req_stream_end;
      end else if (advance_w) begin
         byte_ff <= {byte_ff[6:0], 1'b0};
      end
   end

   always_comb begin
      pix_req.valid    = emit_w;
      pix_req.code     = code_w;
      pix_req.col      = col_ff;
      pix_req.row      = row_ff;
      pix_req.img_end  = img_end_w;
      pix_req.byte_end = advance_w & last_bit_w;
      pix_req.strm_end = end_ff;
   end

   a_prefix_bound: assert property (@(posedge clock) disable iff (reset)
      prefix_ff <= dpg_pkg::PFX_W'(dpg_pkg::PREFIX_LIMIT))
      else $error("prefix count past limit");

   a_suffix_count: assert property (@(posedge clock) disable iff (reset)
      in_suffix_ff |-> (remain_ff != '0))
      else $error("suffix active with no bits left");

   a_done_quiet: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !emit_w)
      else $error("pixel decoded after image end");

endmodule

// ===== sv/dpg_pixel.sv =====
`timescale 1ns / 1ps
module dpg_pixel (
   input  logic                 clock,
   input  logic                 reset,
   input  dpg_pkg::cfg_type     cfg,
   input  dpg_pkg::pix_req_type pix_req,
   output dpg_pkg::pix_res_type pix_res
);

   logic [dpg_pkg::PIX_W-1:0]  above_mem [dpg_pkg::MAX_WIDTH];
   logic [dpg_pkg::PIX_W-1:0]  rd_ff;

   logic                       b_valid_ff, b_byte_end_ff;
   logic [dpg_pkg::CODE_W-1:0] b_code_ff;
   logic [dpg_pkg::COL_W-1:0]  b_col_ff;
   logic [dpg_pkg::ROW_W-1:0]  b_row_ff;
   logic                       b_img_end_ff, b_strm_end_ff;

   logic                       wr_valid_ff;
   logic [dpg_pkg::COL_W-1:0]  wr_col_ff;
   logic [dpg_pkg::PIX_W-1:0]  wr_value_ff;
   logic [dpg_pkg::PIX_W-1:0]  left_ff;

   logic [dpg_pkg::PIX_W-1:0]  above_w, left_w, pred_w, value_w;
   logic [dpg_pkg::PIX_W:0]    avg_sum_w;
   logic [dpg_pkg::CODE_W-2:0] mag_w;
   logic                       neg_w, big_w, col0_w, row0_w;
   logic [dpg_pkg::PIX_W+1:0]  diff_w, sum_w;

   // the write made at the edge that loaded the read data is not yet in it
   assign above_w = (wr_valid_ff && (wr_col_ff == b_col_ff)) ? wr_value_ff : rd_ff;
   assign col0_w  = (b_col_ff == '0);
   assign row0_w  = (b_row_ff == '0);
   // left neighbor is the mid level at every row start
   assign left_w  = col0_w ? dpg_pkg::PIX_MID : left_ff;
   assign avg_sum_w = {1'b0, left_ff} + {1'b0, above_w};

   always_comb begin
      unique case (cfg.pred_mode)
         dpg_pkg::PRED_ABOVE: pred_w = row0_w ? dpg_pkg::PIX_MID : above_w;
         dpg_pkg::PRED_AVG: begin
            if (col0_w && row0_w) begin
               pred_w = dpg_pkg::PIX_MID;
            end else if (col0_w) begin
               pred_w = above_w;
            end else if (row0_w) begin
               pred_w = left_ff;
            end else begin
               pred_w = avg_sum_w[dpg_pkg::PIX_W:1];
            end
         end
         default: pred_w = left_w;
      endcase
   end

   // zigzag unfold: odd codes are negative, -(m+1) is ~m
   assign mag_w  = b_code_ff[dpg_pkg::CODE_W-1:1];
   assign neg_w  = b_code_ff[0];
   assign big_w  = |mag_w[dpg_pkg::CODE_W-2:dpg_pkg::PIX_W];
   assign diff_w = neg_w ? ~{2'b00, mag_w[dpg_pkg::PIX_W-1:0]}
                         : {2'b00, mag_w[dpg_pkg::PIX_W-1:0]};
   assign sum_w  = {2'b00, pred_w} + diff_w;

   always_comb begin
      if (big_w) begin
         value_w = neg_w ? '0 : dpg_pkg::PIX_MAX;
      end else if (sum_w[dpg_pkg::PIX_W+1]) begin
         value_w = '0;
      end else if (sum_w[dpg_pkg::PIX_W]) begin
         value_w = dpg_pkg::PIX_MAX;
      end else begin
         value_w = sum_w[dpg_pkg::PIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (pix_req.valid) begin
         rd_ff <= above_mem[pix_req.col];
      end
      if (b_valid_ff) begin
         above_mem[b_col_ff] <= value_w;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff    <= 1'b0;
         b_byte_end_ff <= 1'b0;
         wr_valid_ff   <= 1'b0;
      end else begin
         b_valid_ff    <= pix_req.valid;
         b_byte_end_ff <= pix_req.byte_end;
         wr_valid_ff   <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      b_code_ff     <= pix_req.code;
      b_col_ff      <= pix_req.col;
      b_row_ff      <= pix_req.row;
      b_img_end_ff  <= pix_req.img_end;
      b_strm_end_ff <= pix_req.strm_end;
      wr_col_ff     <= b_col_ff;
      wr_value_ff   <= value_w;
      if (b_valid_ff) begin
         left_ff <= value_w;
      end
   end

   always_comb begin
      pix_res.valid    = b_valid_ff;
      pix_res.value    = value_w;
      pix_res.col      = b_col_ff;
      pix_res.row      = b_row_ff;
      pix_res.img_end  = b_img_end_ff;
      pix_res.byte_end = b_byte_end_ff;
      pix_res.strm_end = b_strm_end_ff;
   end

endmodule

// ===== sv/dpg_outq.sv =====
`timescale 1ns / 1ps
module dpg_outq (
   input  logic                  clock,
   input  logic                  reset,
   input  dpg_pkg::pix_res_type  pix_res,
   output logic                  room,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output dpg_pkg::out_item_type rsp_item
);

   dpg_pkg::out_item_type     fifo_ff [dpg_pkg::OQ_DEPTH];
   logic [dpg_pkg::OQ_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [dpg_pkg::OQ_CW-1:0] count_ff;

   logic                      hold_valid_ff, hold_valid_in;
   logic                      hold_closed_ff, hold_closed_in;
   dpg_pkg::out_item_type     hold_item_ff, hold_item_in;

   logic                      push_w, pop_w;
   logic [dpg_pkg::OQ_CW:0]   need_w;

   // newest pixel waits in the hold slot until its successor or its byte end shows
   assign push_w = hold_valid_ff & (hold_closed_ff | pix_res.valid);
   assign pop_w  = (count_ff != '0) & ~rsp_stall;

   // everything already in flight plus one more decoded pixel must fit
   assign need_w = {1'b0, count_ff} + (dpg_pkg::OQ_CW+1)'(hold_valid_ff)
                   + (dpg_pkg::OQ_CW+1)'(pix_res.valid) + (dpg_pkg::OQ_CW+1)'(1);
   assign room   = need_w <= (dpg_pkg::OQ_CW+1)'(dpg_pkg::OQ_DEPTH);

   assign rsp_valid = (count_ff != '0);
   assign rsp_item  = fifo_ff[rd_ptr_ff];

   always_comb begin
      hold_valid_in  = hold_valid_ff;
      hold_closed_in = hold_closed_ff;
      hold_item_in   = hold_item_ff;
      if (pix_res.valid) begin
         hold_valid_in               = 1'b1;
         hold_closed_in              = pix_res.byte_end;
         hold_item_in.value          = pix_res.value;
         hold_item_in.col            = pix_res.col;
         hold_item_in.row            = pix_res.row;
         hold_item_in.last_of_byte   = pix_res.byte_end;
         hold_item_in.frame_complete = pix_res.img_end | (pix_res.byte_end & pix_res.strm_end);
      end else if (pix_res.byte_end && hold_valid_ff && !hold_closed_ff) begin
         hold_closed_in              = 1'b1;
         hold_item_in.last_of_byte   = 1'b1;
         hold_item_in.frame_complete = hold_item_ff.frame_complete | pix_res.strm_end;
      end else if (push_w) begin
         hold_valid_in  = 1'b0;
         hold_closed_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff  <= 1'b0;
         hold_closed_ff <= 1'b0;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         count_ff       <= '0;
      end else begin
         hold_valid_ff  <= hold_valid_in;
         hold_closed_ff <= hold_closed_in;
         if (push_w) begin
            wr_ptr_ff <= wr_ptr_ff + dpg_pkg::OQ_AW'(1);
         end
         if (pop_w) begin
            rd_ptr_ff <= rd_ptr_ff + dpg_pkg::OQ_AW'(1);
         end
         case ({push_w, pop_w})
            2'b10:   count_ff <= count_ff + dpg_pkg::OQ_CW'(1);
            2'b01:   count_ff <= count_ff - dpg_pkg::OQ_CW'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      hold_item_ff <= hold_item_in;
      if (push_w) begin
         fifo_ff[wr_ptr_ff] <= hold_item_ff;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (count_ff == dpg_pkg::OQ_CW'(dpg_pkg::OQ_DEPTH)) |-> (!push_w || pop_w))
      else $error("output queue overflow");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= dpg_pkg::OQ_CW'(dpg_pkg::OQ_DEPTH))
      else $error("output queue count out of range");

   a_closed_held: assert property (@(posedge clock) disable iff (reset)
      hold_closed_ff |-> hold_valid_ff)
      else $error("closed hold slot is empty");

endmodule

// ===== sv/dpcm_golomb_pixel_decoder_core.sv =====
`timescale 1ns / 1ps
// dpcm pixel decoder for exp-golomb / rice coded differences
// - req channel: one item per coded byte, msb first; req_stream_end marks the
//   final byte of a frame's bitstream
// - rsp channel: one item per decoded pixel with value, column and row;
//   last_of_byte flags the final pixel a byte produced, frame_complete the
//   pixel that ends the image or the stream
// - csr port: apb-style, registers at 4*i (mode, code kind, rice k, width,
//   height); write only while no item is in flight
// - throughput: one bit decoded per cycle in the bit decoder while the output
//   queue has room; the next byte is taken on the cycle its predecessor's last
//   bit is decoded, so bytes stream back to back
// - pipeline: after the cycle that decodes its final bit, a pixel passes an
//   above-row memory read, reconstruction, then a hold slot until the pixel
//   is known to be or not be the last of its byte, then the queue to rsp
// - reset clears decoder, position and queue state; the above-row memory is
//   not cleared, every entry is written on the first row before it is read
// - a stalled rsp fills an 8-entry queue; the decoder pauses when the queue
//   could overflow, and req_stall rises once the byte buffer is busy
module dpcm_golomb_pixel_decoder_core (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [7:0]                       req_stream_byte,
   input  logic                             req_stream_end,

   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [dpg_pkg::PIX_W-1:0]        rsp_pixel_value,
   output logic [dpg_pkg::COL_W-1:0]        rsp_pixel_column,
   output logic [dpg_pkg::ROW_W-1:0]        rsp_pixel_row,
   output logic                             rsp_last_of_byte,
   output logic                             rsp_frame_complete,

   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [dpg_pkg::CSR_AW-1:0]       paddr,
   input  logic [dpg_pkg::CSR_DW-1:0]       pwdata,
   output logic [dpg_pkg::CSR_DW-1:0]       prdata,
   output logic                             pready
);

   dpg_pkg::cfg_type      cfg_w;
   dpg_pkg::pix_req_type  pix_req_w;
   dpg_pkg::pix_res_type  pix_res_w;
   dpg_pkg::out_item_type head_w;
   logic                  room_w;

   // configuration registers
   dpg_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg_w)
   );

   // byte buffer, bit-serial code parser and pixel position counters
   dpg_decoder u_decoder (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_w),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_stream_byte (req_stream_byte),
      .req_stream_end  (req_stream_end),
      .room            (room_w),
      .pix_req         (pix_req_w)
   );

   // above-row memory read, prediction, difference add and clamp, write back
   dpg_pixel u_pixel (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_w),
      .pix_req (pix_req_w),
      .pix_res (pix_res_w)
   );

   // last-of-byte tagging and output queue
   dpg_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .pix_res   (pix_res_w),
      .room      (room_w),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (head_w)
   );

   assign rsp_pixel_value    = head_w.value;
   assign rsp_pixel_column   = head_w.col;
   assign rsp_pixel_row      = head_w.row;
   assign rsp_last_of_byte   = head_w.last_of_byte;
   assign rsp_frame_complete = head_w.frame_complete;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;

   // mode value with no name in the package, decodes like left prediction
   localparam logic [1:0] PRED_SPARE = 2'd3;
   // run limit, far above the slowest legal run of this stimulus
   localparam int CYCLE_LIMIT = 400000;
   // quiet cycles after the last pixel: a coded byte that yields nothing may
   // still be in the bit decoder or the pixel pipe
   localparam int SETTLE_CYCLES = 32;
   localparam int MAX_REPORTS = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [7:0]                  req_stream_byte = '0;
   logic                        req_stream_end = 1'b0;

   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [dpg_pkg::PIX_W-1:0]   rsp_pixel_value;
   logic [dpg_pkg::COL_W-1:0]   rsp_pixel_column;
   logic [dpg_pkg::ROW_W-1:0]   rsp_pixel_row;
   logic                        rsp_last_of_byte;
   logic                        rsp_frame_complete;

   logic                        psel = 1'b0;
   logic                        penable = 1'b0;
   logic                        pwrite = 1'b0;
   logic [dpg_pkg::CSR_AW-1:0]  paddr = '0;
   logic [dpg_pkg::CSR_DW-1:0]  pwdata = '0;
   logic [dpg_pkg::CSR_DW-1:0]  prdata;
   logic                        pready;

   dpcm_golomb_pixel_decoder_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_stream_byte    (req_stream_byte),
      .req_stream_end     (req_stream_end),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pixel_value    (rsp_pixel_value),
      .rsp_pixel_column   (rsp_pixel_column),
      .rsp_pixel_row      (rsp_pixel_row),
      .rsp_last_of_byte   (rsp_last_of_byte),
      .rsp_frame_complete (rsp_frame_complete),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // decoder state as the pixels should see it
   // ---------------------------------------------------------------

   // register copies, reset values
   logic [1:0]                cfg_mode = dpg_pkg::PRED_LEFT;
   dpg_pkg::code_kind_type    cfg_kind = dpg_pkg::KIND_EXPG;
   logic [dpg_pkg::K_W-1:0]   cfg_k = '0;
   logic [dpg_pkg::DIM_W-1:0] cfg_w = 9'd128;
   logic [dpg_pkg::DIM_W-1:0] cfg_h = 9'd144;

   // previous row, only ever used after this frame wrote it
   logic [dpg_pkg::PIX_W-1:0] above_px [dpg_pkg::MAX_WIDTH];
   int unsigned      left_px = dpg_pkg::PIX_MID;
   int unsigned      col_cnt = 0;
   int unsigned      row_cnt = 0;
   bit               in_sfx = 1'b0;
   bit               img_done = 1'b0;
   int unsigned      pfx_zeros = 0;
   int unsigned      sfx_left = 0;
   longint unsigned  sfx_bits = 0;

   // pixels still owed by the block, oldest first
   dpg_pkg::out_item_type pending_pixels [$];
   // bytes that reached the decoder before the image was full
   int unsigned      coded_bytes = 0;

   int               error_count = 0;
   int               cycle_count = 0;
   int               sender_idle = 0;
   int               stall_pct = 0;

   // bitstream under construction, msb of the first byte first
   bit               code_bits [$];

   function automatic int unsigned rice_bits();
      return (cfg_k > dpg_pkg::MAX_RICE_K) ? dpg_pkg::MAX_RICE_K : cfg_k;
   endfunction

   function automatic void clear_code();
      in_sfx = 1'b0;
      pfx_zeros = 0;
      sfx_bits = 0;
      sfx_left = 0;
   endfunction

   function automatic void clear_frame();
      clear_code();
      left_px = dpg_pkg::PIX_MID;
      col_cnt = 0;
      row_cnt = 0;
      img_done = 1'b0;
   endfunction

   // unfold the code number, add it to the prediction, clamp, advance position
   function automatic void reconstruct_pixel(longint unsigned code);
      longint                diff, pred, v;
      int unsigned           ab, w, h;
      dpg_pkg::out_item_type px;
      // zigzag: even n gives n/2, odd n gives -(n+1)/2
      diff = code[0] ? -longint'((code >> 1) + 1) : longint'(code >> 1);
      ab = (col_cnt < dpg_pkg::MAX_WIDTH) ? above_px[col_cnt] : 0;
      if (cfg_mode == dpg_pkg::PRED_ABOVE) begin
         pred = (row_cnt != 0) ? ab : dpg_pkg::PIX_MID;
      end else if (cfg_mode == dpg_pkg::PRED_AVG) begin
         // corner, left column and top row each have their own source
         if (col_cnt == 0 && row_cnt == 0) pred = dpg_pkg::PIX_MID;
         else if (col_cnt == 0) pred = ab;
         else if (row_cnt == 0) pred = left_px;
         else pred = (left_px + ab) >> 1;
      end else begin
         pred = left_px;
      end
      v = pred + diff;
      if (v < 0) v = 0;
      if (v > dpg_pkg::PIX_MAX) v = dpg_pkg::PIX_MAX;
      if (col_cnt < dpg_pkg::MAX_WIDTH) above_px[col_cnt] = v[dpg_pkg::PIX_W-1:0];
      left_px = 32'(v);
      px.value = v[dpg_pkg::PIX_W-1:0];
      px.col = col_cnt[dpg_pkg::COL_W-1:0];
      px.row = row_cnt[dpg_pkg::ROW_W-1:0];
      px.last_of_byte = 1'b0;
      px.frame_complete = 1'b0;
      // zero size acts as one, oversize saturates
      w = (cfg_w == 0) ? 1 :
          ((cfg_w > dpg_pkg::MAX_WIDTH) ? dpg_pkg::MAX_WIDTH : cfg_w);
      h = (cfg_h == 0) ? 1 :
          ((cfg_h > dpg_pkg::MAX_HEIGHT) ? dpg_pkg::MAX_HEIGHT : cfg_h);
      if (col_cnt + 1 >= w) begin
         col_cnt = 0;
         left_px = dpg_pkg::PIX_MID;
         if (row_cnt + 1 >= h) begin
            img_done = 1'b1;
            px.frame_complete = 1'b1;
         end else begin
            row_cnt++;
         end
      end else begin
         col_cnt++;
      end
      pending_pixels.push_back(px);
   endfunction

   // one accepted byte: walk its bits msb first and queue the pixels it yields
   function automatic void decode_byte(logic [7:0] b, logic e);
      int              made;
      longint unsigned code;
      made = 0;
      if (!img_done) coded_bytes++;
      for (int i = 7; i >= 0; i--) begin
         // full image: bits are dropped until the end-of-stream byte
         if (img_done) continue;
         if (!in_sfx) begin
            if (!b[i]) begin
               pfx_zeros++;
               // runaway prefix ends the code with a zero difference
               if (pfx_zeros > dpg_pkg::PREFIX_LIMIT) begin
                  clear_code();
                  reconstruct_pixel(0);
                  made++;
               end
            end else if (cfg_kind == dpg_pkg::KIND_EXPG) begin
               if (pfx_zeros == 0) begin
                  clear_code();
                  reconstruct_pixel(0);
                  made++;
               end else begin
                  in_sfx = 1'b1;
                  sfx_bits = 0;
                  sfx_left = pfx_zeros;
               end
            end else if (rice_bits() == 0) begin
               code = pfx_zeros;
               clear_code();
               reconstruct_pixel(code);
               made++;
            end else begin
               in_sfx = 1'b1;
               sfx_bits = 0;
               sfx_left = rice_bits();
            end
         end else begin
            sfx_bits = (sfx_bits << 1) | b[i];
            if (sfx_left <= 1) begin
               if (cfg_kind == dpg_pkg::KIND_EXPG)
                  code = ((64'd1 << pfx_zeros) - 1) + sfx_bits;
               else
                  code = (longint'(pfx_zeros) << rice_bits()) + sfx_bits;
               clear_code();
               reconstruct_pixel(code);
               made++;
            end else begin
               sfx_left--;
            end
         end
      end
      if (made > 0) begin
         pending_pixels[$].last_of_byte = 1'b1;
         if (e) pending_pixels[$].frame_complete = 1'b1;
      end
      // a code cut short by the end of stream is simply dropped
      if (e) clear_frame();
   endfunction

   // ---------------------------------------------------------------
   // bitstream building
   // ---------------------------------------------------------------

   function automatic void put_bits(longint unsigned v, int nb);
      for (int i = nb - 1; i >= 0; i--) code_bits.push_back(v[i]);
   endfunction

   // order-0 exp-golomb: lz zeros, then n+1 in lz+1 bits
   function automatic void put_expg(longint unsigned n);
      longint unsigned m;
      int              lz;
      m = n + 1;
      lz = 0;
      while ((m >> (lz + 1)) != 0) lz++;
      put_bits(0, lz);
      put_bits(m, lz + 1);
   endfunction

   function automatic void put_rice(int q, longint unsigned r);
      put_bits(0, q);
      put_bits(1, 1);
      put_bits(r, rice_bits());
   endfunction

   function automatic longint unsigned fold(longint d);
      return (d >= 0) ? longint'(2 * d) : longint'(-2 * d - 1);
   endfunction

   // ---------------------------------------------------------------
   // drivers and checker
   // ---------------------------------------------------------------

   task automatic report_error(string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("%s", msg);
   endtask

   // apb write: setup, then access until pready; copy takes effect with it
   task automatic write_reg(dpg_pkg::reg_index_type idx, int unsigned val);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= dpg_pkg::CSR_AW'({idx, 2'b00});
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         dpg_pkg::REG_PRED_MODE:  cfg_mode = val[1:0];
         dpg_pkg::REG_CODE_KIND:  cfg_kind = dpg_pkg::code_kind_type'(val[0]);
         dpg_pkg::REG_RICE_K:     cfg_k = val[dpg_pkg::K_W-1:0];
         dpg_pkg::REG_IMG_WIDTH:  cfg_w = val[dpg_pkg::DIM_W-1:0];
         dpg_pkg::REG_IMG_HEIGHT: cfg_h = val[dpg_pkg::DIM_W-1:0];
         default: ;
      endcase
   endtask

   // one item on req; valid is left high so back-to-back bytes need no gap
   task automatic send_byte(logic [7:0] b, logic e);
      while ($urandom_range(99) < sender_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_stream_byte <= b;
      req_stream_end <= e;
      do @(posedge clock); while (req_stall);
      decode_byte(b, e);
   endtask

   // pack the built bits into bytes, pad with noise, last byte ends the stream
   task automatic send_stream();
      logic [7:0] b;
      int         nbytes;
      if (code_bits.size() == 0) put_bits($urandom, 8);
      while (code_bits.size() % 8 != 0) code_bits.push_back($urandom_range(0, 1));
      nbytes = code_bits.size() / 8;
      for (int n = 0; n < nbytes; n++) begin
         for (int i = 0; i < 8; i++) b[7 - i] = code_bits[8 * n + i];
         send_byte(b, n == nbytes - 1);
      end
      code_bits.delete();
   endtask

   // block idle: every owed pixel seen, then the tail of the pipe
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // receiver backpressure
   always @(posedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   // every accepted pixel against the oldest owed one
   dpg_pkg::out_item_type got_px, want_px;
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got_px = {rsp_pixel_value, rsp_pixel_column, rsp_pixel_row,
                   rsp_last_of_byte, rsp_frame_complete};
         if (pending_pixels.size() == 0) begin
            report_error($sformatf("unexpected pixel: value %0d col %0d row %0d lob %0b fc %0b",
               got_px.value, got_px.col, got_px.row, got_px.last_of_byte,
               got_px.frame_complete));
         end else begin
            want_px = pending_pixels.pop_front();
            if (got_px !== want_px)
               report_error($sformatf({"pixel mismatch: expected value %0d col %0d row %0d",
                  " lob %0b fc %0b, got value %0d col %0d row %0d lob %0b fc %0b"},
                  want_px.value, want_px.col, want_px.row, want_px.last_of_byte,
                  want_px.frame_complete, got_px.value, got_px.col, got_px.row,
                  got_px.last_of_byte, got_px.frame_complete));
         end
      end
   end

   // hang guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // reset settings: eight zero codes in one byte, largest exp-golomb code
   // (clamps high), big negative (clamps low), runaway prefix, cut-off code
   task automatic test_expg_limits();
      sender_idle = 0;
      stall_pct = 0;
      put_bits(8'hFF, 8);
      put_expg((64'd1 << (dpg_pkg::PREFIX_LIMIT + 1)) - 2);
      put_expg(fold(-300));
      put_bits(0, dpg_pkg::PREFIX_LIMIT + 1);
      put_bits(0, 3);
      send_stream();
      wait_idle();
   endtask

   // rice at the largest k with the longest legal prefix, spare mode,
   // oversize-free small image that wraps to a second row
   task automatic test_rice_limits();
      write_reg(dpg_pkg::REG_PRED_MODE, PRED_SPARE);
      write_reg(dpg_pkg::REG_CODE_KIND, dpg_pkg::KIND_RICE);
      write_reg(dpg_pkg::REG_RICE_K, dpg_pkg::MAX_RICE_K);
      write_reg(dpg_pkg::REG_IMG_WIDTH, 3);
      write_reg(dpg_pkg::REG_IMG_HEIGHT, 2);
      stall_pct = 53;
      put_rice(dpg_pkg::PREFIX_LIMIT, (1 << dpg_pkg::MAX_RICE_K) - 1);
      put_rice(0, 0);
      put_bits(0, dpg_pkg::PREFIX_LIMIT + 1);
      put_rice(1, 5);
      put_bits(0, 2);
      send_stream();
      wait_idle();
   endtask

   // zero width and height act as 1x1: first pixel completes the image and
   // the rest of the stream, end byte included, is dropped
   task automatic test_image_done();
      write_reg(dpg_pkg::REG_PRED_MODE, dpg_pkg::PRED_ABOVE);
      write_reg(dpg_pkg::REG_CODE_KIND, dpg_pkg::KIND_EXPG);
      write_reg(dpg_pkg::REG_IMG_WIDTH, 0);
      write_reg(dpg_pkg::REG_IMG_HEIGHT, 0);
      sender_idle = 28;
      stall_pct = 28;
      send_byte(8'hFF, 1'b0);
      send_byte(8'hAA, 1'b1);
      wait_idle();
   endtask

   // every register, extremes now and then; small images so rows wrap
   task automatic randomize_config();
      int unsigned w, h;
      case ($urandom_range(0, 9))
         0: w = 0;
         1: w = dpg_pkg::MAX_WIDTH;
         2: w = (1 << dpg_pkg::DIM_W) - 1;
         default: w = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 9))
         0: h = 0;
         1: h = dpg_pkg::MAX_HEIGHT;
         2: h = (1 << dpg_pkg::DIM_W) - 1;
         default: h = $urandom_range(1, 6);
      endcase
      write_reg(dpg_pkg::REG_PRED_MODE, $urandom_range(0, 3));
      write_reg(dpg_pkg::REG_CODE_KIND, $urandom_range(0, 1));
      write_reg(dpg_pkg::REG_RICE_K, $urandom_range(0, (1 << dpg_pkg::K_W) - 1));
      write_reg(dpg_pkg::REG_IMG_WIDTH, w);
      write_reg(dpg_pkg::REG_IMG_HEIGHT, h);
   endtask

   // mostly well-formed codes for the current settings, with runaway
   // prefixes, stray bytes and now and then a frame of pure noise
   task automatic build_random_frame();
      int              sel, lz;
      longint unsigned m;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 6)) put_bits($urandom, 8);
         return;
      end
      repeat ($urandom_range(3, 30)) begin
         sel = $urandom_range(0, 99);
         if (sel < 5) begin
            put_bits(0, $urandom_range(dpg_pkg::PREFIX_LIMIT + 1, dpg_pkg::PREFIX_LIMIT + 3));
         end else if (sel < 10) begin
            put_bits($urandom, 8);
         end else if (cfg_kind == dpg_pkg::KIND_EXPG) begin
            if (sel < 16) begin
               lz = $urandom_range(12, dpg_pkg::PREFIX_LIMIT);
               m = (64'd1 << lz) | ({$urandom, $urandom} & ((64'd1 << lz) - 1));
               put_expg(m - 1);
            end else if (sel < 25) begin
               put_expg(fold(int'($urandom_range(0, 600)) - 300));
            end else begin
               put_expg(fold(int'($urandom_range(0, 80)) - 40));
            end
         end else begin
            put_rice((sel < 16) ? $urandom_range(10, dpg_pkg::PREFIX_LIMIT)
                                : $urandom_range(0, 5),
                     $urandom);
         end
      end
   endtask

   // frames until enough bytes reached the decoder under this idling mix
   task automatic test_random_traffic(int idle, int stall, int unsigned target);
      int unsigned start;
      sender_idle = idle;
      stall_pct = stall;
      start = coded_bytes;
      while (coded_bytes - start < target) begin
         randomize_config();
         build_random_frame();
         send_stream();
         wait_idle();
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_expg_limits();
      test_rice_limits();
      test_image_done();
      test_random_traffic(0, 0, 15);
      test_random_traffic(53, 0, 15);
      test_random_traffic(0, 53, 15);
      test_random_traffic(28, 28, 15);
      wait_idle();
      if (error_count == 0 && pending_pixels.size() == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule
